// File: hdl/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// No dependencies; every other file imports this package.
package modexp_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SCAN,
        ST_SQUARE,
        ST_MULT,
        ST_OUT
    } mx_state_t;

    // Status of a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    localparam int unsigned REG_MODULUS  = 0;
    localparam int unsigned REG_EXPONENT = 1;

endpackage

// File: hdl/modexp_reduce.sv
// Bit-serial remainder unit: dividend mod modulus, one dividend bit per cycle.
// Depends on modexp_pkg.
module modexp_reduce #(
    parameter int WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [WIDTH-1:0]       dividend,
    input  logic [WIDTH-1:0]       modulus,
    output logic [WIDTH-1:0]       remainder,
    output modexp_pkg::unit_stat_t stat
);
    import modexp_pkg::*;

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] sh_reg, sh_next;

    logic             mod_zero;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   trial;

    assign mod_zero = (modulus == '0);
    assign shifted  = {rem_reg, sh_reg[WIDTH-1]};
    // Remainder stays below modulus, so one conditional subtract suffices.
    assign trial    = (!mod_zero && shifted >= {1'b0, modulus}) ?
                      shifted - {1'b0, modulus} : shifted;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_LAST;
            rem_next  = '0;
            sh_next   = dividend;
        end else if (busy_reg) begin
            rem_next = trial[WIDTH-1:0];
            sh_next  = {sh_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: hdl/modexp_mulmod.sv
// Bit-serial modular multiplier: op_a * op_b mod modulus, one op_b bit per cycle.
// Depends on modexp_pkg. Operands must already be below the modulus.
module modexp_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [WIDTH-1:0]       op_a,
    input  logic [WIDTH-1:0]       op_b,
    input  logic [WIDTH-1:0]       modulus,
    output logic [WIDTH-1:0]       product,
    output modexp_pkg::unit_stat_t stat
);
    import modexp_pkg::*;

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;

    logic             mod_zero;
    logic [WIDTH:0]   dbl_sum, dbl_red;
    logic [WIDTH:0]   add_sum, add_red;

    // Zero modulus means plain wrap at WIDTH bits.
    assign mod_zero = (modulus == '0);
    assign dbl_sum  = {acc_reg, 1'b0};
    assign dbl_red  = (!mod_zero && dbl_sum >= {1'b0, modulus}) ?
                      dbl_sum - {1'b0, modulus} : dbl_sum;
    assign add_sum  = {1'b0, dbl_red[WIDTH-1:0]} +
                      (b_reg[WIDTH-1] ? {1'b0, a_reg} : {(WIDTH+1){1'b0}});
    assign add_red  = (!mod_zero && add_sum >= {1'b0, modulus}) ?
                      add_sum - {1'b0, modulus} : add_sum;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_LAST;
            acc_next  = '0;
            a_next    = op_a;
            b_next    = op_b;
        end else if (busy_reg) begin
            acc_next = add_red[WIDTH-1:0];
            b_next   = {b_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: hdl/modular_exponentiation_top.sv
// Top level of the modular exponentiation block: APB registers, sequencer,
// output register. Depends on modexp_pkg, modexp_reduce and modexp_mulmod.
//
//  channel   direction  handshake          payload
//  -------   ---------  -----------------  --------------------------------
//  input     in         s_valid / s_ready  s_base       (WIDTH bits)
//  result    out        m_valid / m_ready  m_power_result (WIDTH bits)
//  config    in         APB psel/penable   modulus @ 0, exponent @ 4 (8 if WIDTH > 32)
//
// One word at a time. A word passes through base reduction, a scan for the top
// set exponent bit, then a squaring per exponent bit from there down and a
// multiply per set bit, all on the bit-serial multiplier. A zero exponent
// skips reduction and goes straight to the output state.
// Reset clears control state and sets modulus and exponent to 1.
// A stalled result holds in the output register while the next word runs.
module modular_exponentiation_top #(
    parameter int WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [WIDTH-1:0]                  s_base,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [WIDTH-1:0]                  m_power_result,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [((WIDTH > 32) ? 3 : 2):0]   paddr,
    input  logic [((WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic                              pready
);
    import modexp_pkg::*;

    localparam int PW  = (WIDTH > 32) ? 64 : 32;
    localparam int ASH = (WIDTH > 32) ? 3 : 2;
    localparam int CW  = $clog2(WIDTH);
    localparam logic [CW-1:0] BITS_TOP = CW'(WIDTH - 1);
    localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

    // Configuration registers
    logic [WIDTH-1:0] modulus_reg;
    logic [WIDTH-1:0] exponent_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= ONE;
            exponent_reg <= ONE;
        end else if (cfg_write) begin
            if (paddr[ASH] == 1'(REG_MODULUS)) begin
                modulus_reg <= pwdata[WIDTH-1:0];
            end else begin
                exponent_reg <= pwdata[WIDTH-1:0];
            end
        end
    end

    // Read back the addressed register.
    assign prdata = (paddr[ASH] == 1'(REG_EXPONENT)) ? PW'(exponent_reg) : PW'(modulus_reg);

    // Sequencer state
    mx_state_t        state_reg, state_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] base_reg, base_next;
    logic [WIDTH-1:0] exp_sh_reg, exp_sh_next;
    logic [CW-1:0]    bits_left_reg, bits_left_next;
    logic             m_valid_reg, m_valid_next;
    logic [WIDTH-1:0] m_power_result_reg, m_power_result_next;

    // Arithmetic unit hookup
    logic             rd_start;
    logic [WIDTH-1:0] rd_rem;
    unit_stat_t       rd_stat;
    logic             mm_start;
    logic [WIDTH-1:0] mm_a, mm_b, mm_prod;
    unit_stat_t       mm_stat;
    logic             advance;

    modexp_reduce #(.WIDTH(WIDTH)) u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rd_start),
        .dividend  (s_base),
        .modulus   (modulus_reg),
        .remainder (rd_rem),
        .stat      (rd_stat)
    );

    modexp_mulmod #(.WIDTH(WIDTH)) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .modulus (modulus_reg),
        .product (mm_prod),
        .stat    (mm_stat)
    );

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next          = state_reg;
        acc_next            = acc_reg;
        base_next           = base_reg;
        exp_sh_next         = exp_sh_reg;
        bits_left_next      = bits_left_reg;
        m_power_result_next = m_power_result_reg;
        // Drop the held result once taken.
        m_valid_next        = m_valid_reg && !m_ready;
        rd_start            = 1'b0;
        mm_start            = 1'b0;
        mm_a                = acc_reg;
        mm_b                = acc_reg;
        advance             = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (exponent_reg == '0) begin
                        // Zero exponent returns 1, unreduced.
                        acc_next   = ONE;
                        state_next = ST_OUT;
                    end else begin
                        rd_start       = 1'b1;
                        acc_next       = (modulus_reg == ONE) ? '0 : ONE;
                        exp_sh_next    = exponent_reg;
                        bits_left_next = BITS_TOP;
                        state_next     = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (rd_stat.done) begin
                    base_next  = rd_rem;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Skip leading zero exponent bits one per cycle.
                if (exp_sh_reg[WIDTH-1]) begin
                    mm_start   = 1'b1;
                    state_next = ST_SQUARE;
                end else begin
                    exp_sh_next    = {exp_sh_reg[WIDTH-2:0], 1'b0};
                    bits_left_next = bits_left_reg - 1'b1;
                end
            end
            ST_SQUARE: begin
                if (mm_stat.done) begin
                    acc_next = mm_prod;
                    if (exp_sh_reg[WIDTH-1]) begin
                        mm_start   = 1'b1;
                        mm_a       = mm_prod;
                        mm_b       = base_reg;
                        state_next = ST_MULT;
                    end else begin
                        advance = 1'b1;
                    end
                end
            end
            ST_MULT: begin
                if (mm_stat.done) begin
                    acc_next = mm_prod;
                    advance  = 1'b1;
                end
            end
            ST_OUT: begin
                // Load the output register when it is free or being emptied.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_power_result_next = acc_reg;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Advance to the next exponent bit and launch its squaring, or go to output after the last bit.
        if (advance) begin
            if (bits_left_reg == '0) begin
                state_next = ST_OUT;
            end else begin
                exp_sh_next    = {exp_sh_reg[WIDTH-2:0], 1'b0};
                bits_left_next = bits_left_reg - 1'b1;
                mm_start       = 1'b1;
                mm_a           = mm_prod;
                mm_b           = mm_prod;
                state_next     = ST_SQUARE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            bits_left_reg <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            bits_left_reg <= bits_left_next;
        end
        acc_reg            <= acc_next;
        base_reg           <= base_next;
        exp_sh_reg         <= exp_sh_next;
        m_power_result_reg <= m_power_result_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_power_result = m_power_result_reg;

    // Both serial units are quiet whenever a new word may enter.
    a_idle_units: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!mm_stat.busy && !rd_stat.busy))
        else $error("arithmetic unit busy while sequencer idle");

    // A multiplier finish only lands where the sequencer waits for it.
    a_mm_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_stat.done |-> (state_reg == ST_SQUARE || state_reg == ST_MULT))
        else $error("multiplier finished outside a multiply state");

    // A reduction finish only lands in the reduction wait.
    a_rd_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_stat.done |-> (state_reg == ST_REDUCE))
        else $error("reduction finished outside its wait state");

    // The multiplier is never restarted while it runs.
    a_mm_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_start |-> !mm_stat.busy)
        else $error("multiplier started while busy");

endmodule
